// File: src/spwm_pkg.sv
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared constants, types and the sine duty tables of the sine PWM sequencer.
// ----------------------------------------------------------------------------
package spwm_pkg;

  // Table steps per sine period (valid range 8 to 256).
  localparam int PeriodSteps = 200;
  localparam int AddrW       = $clog2(PeriodSteps);
  localparam int HalfSteps   = PeriodSteps / 2;
  localparam int PhaseW      = 8;
  localparam int DutyW       = 7;
  localparam int DutyMax     = 100;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 8;

  // Q30 fixed point for the table build
  localparam logic [63:0] QOne    = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBridgeMode = 3'd0,
    CfgEnableB    = 3'd1,
    CfgEnableC    = 3'd2,
    CfgPhaseB     = 3'd3,
    CfgPhaseC     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              bridge_mode;
    logic              enable_b;
    logic              enable_c;
    logic [PhaseW-1:0] phase_b;
    logic [PhaseW-1:0] phase_c;
  } cfg_t;

  // One item after address generation
  typedef struct packed {
    logic             tick;
    logic             bridge_mode;
    logic             enable_b;
    logic             enable_c;
    logic [AddrW-1:0] addr_b;
    logic [AddrW-1:0] addr_c;
  } item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_b;
    logic             load_b;
    logic [DutyW-1:0] duty_c;
    logic             load_c;
  } result_t;

  typedef logic [DutyW-1:0] rom_t [PeriodSteps];

  // sin((pi/2) * e / PeriodSteps) in Q30, odd series to x^13
  function automatic logic [63:0] quarter_sin(input logic [63:0] e);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = HalfPiQ * e / 64'(PeriodSteps);
    x2 = x * x / QOne;
    t  = QOne;
    // Horner steps, divisor k*(k-1) for k = 13, 11, 9, 7, 5, 3
    t  = QOne - (x2 * t / QOne) / 64'd156;
    t  = QOne - (x2 * t / QOne) / 64'd110;
    t  = QOne - (x2 * t / QOne) / 64'd72;
    t  = QOne - (x2 * t / QOne) / 64'd42;
    t  = QOne - (x2 * t / QOne) / 64'd20;
    t  = QOne - (x2 * t / QOne) / 64'd6;
    return x * t / QOne;
  endfunction

  function automatic logic [DutyW-1:0] clamp_duty(input logic [63:0] v);
    return (v > 64'(DutyMax)) ? DutyW'(DutyMax) : v[DutyW-1:0];
  endfunction

  // bridge = 0: round(50 + 50*sin), bridge = 1: |round(100*sin)|
  function automatic rom_t build_rom(input logic bridge);
    rom_t        rom;
    logic [63:0] e;
    logic [63:0] mag;
    logic        neg;
    for (int a = 0; a < PeriodSteps; a++) begin
      e   = 64'(4 * a);
      neg = 1'b0;
      if (e >= 64'(2 * PeriodSteps)) begin
        neg = 1'b1;
        e   = e - 64'(2 * PeriodSteps);
      end
      if (e > 64'(PeriodSteps)) begin
        e = 64'(2 * PeriodSteps) - e;
      end
      mag = quarter_sin(e);
      if (mag > QOne) begin
        mag = QOne;
      end
      if (bridge) begin
        rom[a] = clamp_duty((64'd100 * mag + QOne / 2) / QOne);
      end else if (neg) begin
        rom[a] = clamp_duty((64'd50 * QOne - 64'd50 * mag + QOne / 2) / QOne);
      end else begin
        rom[a] = clamp_duty((64'd50 * QOne + 64'd50 * mag + QOne / 2) / QOne);
      end
    end
    return rom;
  endfunction

  localparam rom_t RomIndep  = build_rom(1'b0);
  localparam rom_t RomBridge = build_rom(1'b1);

endpackage

// File: src/sine_pwm_duty_sequencer.sv
// ----------------------------------------------------------------------------
// sine_pwm_duty_sequencer
// Sine table PWM duty sequencer for two outputs, independent or bridge mode.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  -------------------------------
//   in       sink       in_valid_i/in_stall_o  tick_i
//   out      source     out_valid_o/out_stall_i duty_b_o load_b_o duty_c_o load_c_o
//   cfg      sink       cfg_we_i               cfg_idx_i cfg_wdata_i
//
// One item per cycle while out_stall_i is low: the step counters advance and
// the table addresses are formed at acceptance, the table lookup sits between
// the item register and the result register.
// Reset clears the counters, the configuration and both valid flags; the
// sine tables are constants and need no fill.
// A stalled result holds the result register; the item register keeps taking
// an item until it too is full, then in_stall_o rises.
// ----------------------------------------------------------------------------
module sine_pwm_duty_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          tick_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spwm_pkg::DutyW-1:0]    duty_b_o,
  output logic                          load_b_o,
  output logic [spwm_pkg::DutyW-1:0]    duty_c_o,
  output logic                          load_c_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [spwm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spwm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  spwm_pkg::cfg_t    cfg_q, cfg_d;
  spwm_pkg::item_t   item_d, item_q;
  spwm_pkg::result_t res_d, res_q;
  logic              item_valid_q, item_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              item_move;
  logic              in_accept;

  // Configuration registers; unknown indexes drop the write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (spwm_pkg::cfg_idx_e'(cfg_idx_i))
        spwm_pkg::CfgBridgeMode: cfg_d.bridge_mode = cfg_wdata_i[0];
        spwm_pkg::CfgEnableB:    cfg_d.enable_b    = cfg_wdata_i[0];
        spwm_pkg::CfgEnableC:    cfg_d.enable_c    = cfg_wdata_i[0];
        spwm_pkg::CfgPhaseB:     cfg_d.phase_b     = cfg_wdata_i[spwm_pkg::PhaseW-1:0];
        spwm_pkg::CfgPhaseC:     cfg_d.phase_c     = cfg_wdata_i[spwm_pkg::PhaseW-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  // Pipeline control: the result register frees when empty or taken, the
  // item register moves on whenever the result register is free.
  always_comb begin
    out_free     = !out_valid_q || !out_stall_i;
    item_move    = item_valid_q && out_free;
    in_stall_o   = item_valid_q && !out_free;
    in_accept    = in_valid_i && !in_stall_o;
    item_valid_d = in_accept || (item_valid_q && !item_move);
    out_valid_d  = item_move || (out_valid_q && !out_free);
  end

  // Advance the step counters and form the table addresses.
  spwm_step_gen u_step_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .tick_i   (tick_i),
    .cfg_i    (cfg_q),
    .item_o   (item_d)
  );

  // Look up the duties of the held item.
  spwm_duty_map u_duty_map (
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '0;
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: load on move, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= item_d;
    end
    if (item_move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_b_o    = res_q.duty_b;
  assign load_b_o    = res_q.load_b;
  assign duty_c_o    = res_q.duty_c;
  assign load_c_o    = res_q.load_c;

`ifndef ASSERT_OFF
  a_accept_fills_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> item_valid_q)
    else $error("accepted item not held in item register");

  a_no_load_zero_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !load_b_o |-> duty_b_o == '0)
    else $error("duty_b nonzero without load_b");

  a_no_load_zero_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !load_c_o |-> duty_c_o == '0)
    else $error("duty_c nonzero without load_c");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_b_o <= spwm_pkg::DutyW'(spwm_pkg::DutyMax) &&
                    duty_c_o <= spwm_pkg::DutyW'(spwm_pkg::DutyMax))
    else $error("duty above full scale");
`endif

endmodule

// File: src/spwm_step_gen.sv
// ----------------------------------------------------------------------------
// spwm_step_gen
// Step counters of outputs B and C and table address generation per item.
// ----------------------------------------------------------------------------
module spwm_step_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                tick_i,
  input  spwm_pkg::cfg_t      cfg_i,
  output spwm_pkg::item_t     item_o
);

  logic [spwm_pkg::AddrW-1:0] step_b_q, step_b_d;
  logic [spwm_pkg::AddrW-1:0] step_c_q, step_c_d;
  logic                       adv_b, adv_c;

  // Clamp the phase below the period.
  function automatic logic [spwm_pkg::AddrW-1:0] clamp_phase(
    input logic [spwm_pkg::PhaseW-1:0] phase
  );
    logic [spwm_pkg::PhaseW:0] wide;
    wide = {1'b0, phase};
    if (wide >= (spwm_pkg::PhaseW+1)'(spwm_pkg::PeriodSteps)) begin
      return spwm_pkg::AddrW'(spwm_pkg::PeriodSteps - 1);
    end
    return wide[spwm_pkg::AddrW-1:0];
  endfunction

  // (phase + step) mod period, both operands below the period
  function automatic logic [spwm_pkg::AddrW-1:0] address_of(
    input logic [spwm_pkg::PhaseW-1:0] phase,
    input logic [spwm_pkg::AddrW-1:0]  step
  );
    logic [spwm_pkg::AddrW:0] sum;
    sum = (spwm_pkg::AddrW+1)'(clamp_phase(phase)) + (spwm_pkg::AddrW+1)'(step);
    if (sum >= (spwm_pkg::AddrW+1)'(spwm_pkg::PeriodSteps)) begin
      sum = sum - (spwm_pkg::AddrW+1)'(spwm_pkg::PeriodSteps);
    end
    return sum[spwm_pkg::AddrW-1:0];
  endfunction

  function automatic logic [spwm_pkg::AddrW-1:0] next_step(
    input logic [spwm_pkg::AddrW-1:0] step
  );
    return (step == spwm_pkg::AddrW'(spwm_pkg::PeriodSteps - 1)) ?
           '0 : step + spwm_pkg::AddrW'(1);
  endfunction

  always_comb begin
    adv_b = accept_i && tick_i && (cfg_i.bridge_mode || cfg_i.enable_b);
    adv_c = accept_i && tick_i && !cfg_i.bridge_mode && cfg_i.enable_c;
    step_b_d = adv_b ? next_step(step_b_q) : step_b_q;
    step_c_d = adv_c ? next_step(step_c_q) : step_c_q;

    item_o.tick        = tick_i;
    item_o.bridge_mode = cfg_i.bridge_mode;
    item_o.enable_b    = cfg_i.enable_b;
    item_o.enable_c    = cfg_i.enable_c;
    item_o.addr_b      = address_of(cfg_i.phase_b, step_b_q);
    item_o.addr_c      = address_of(cfg_i.phase_c, step_c_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_b_q <= '0;
      step_c_q <= '0;
    end else begin
      step_b_q <= step_b_d;
      step_c_q <= step_c_d;
    end
  end

endmodule

// File: src/spwm_duty_map.sv
// ----------------------------------------------------------------------------
// spwm_duty_map
// Sine table lookup and mapping of table values onto the B and C duties.
// ----------------------------------------------------------------------------
module spwm_duty_map (
  input  spwm_pkg::item_t   item_i,
  output spwm_pkg::result_t result_o
);

  logic [spwm_pkg::DutyW-1:0] bridge_val;

  always_comb begin
    bridge_val = spwm_pkg::RomBridge[item_i.addr_b];
    result_o   = '0;
    if (item_i.tick) begin
      if (item_i.bridge_mode) begin
        // first half-period drives B, second half drives C
        if (item_i.addr_b < spwm_pkg::AddrW'(spwm_pkg::HalfSteps)) begin
          result_o.duty_b = bridge_val;
        end else begin
          result_o.duty_c = bridge_val;
        end
        result_o.load_b = 1'b1;
        result_o.load_c = 1'b1;
      end else begin
        if (item_i.enable_b) begin
          result_o.duty_b = spwm_pkg::RomIndep[item_i.addr_b];
          result_o.load_b = 1'b1;
        end
        if (item_i.enable_c) begin
          result_o.duty_c = spwm_pkg::RomIndep[item_i.addr_c];
          result_o.load_c = 1'b1;
        end
      end
    end
  end

endmodule
